>>> sv/owsm_pkg.sv
// Shared types, constants and the cosine table builder for the omni wheel speed mixer.
package owsm_pkg;

	// Wheel direction codes
	typedef enum logic [1:0] {
		DIR_FWD   = 2'd0,
		DIR_REV   = 2'd1,
		DIR_BRAKE = 2'd2
	} dir_t;

	localparam int unsigned NUM_WHEELS = 4;
	localparam int unsigned SPEED_W    = 16;
	localparam int unsigned DEG_W      = 9;
	localparam int unsigned ROT_W      = 16;
	localparam int unsigned ROM_DEPTH  = 91;
	localparam int unsigned ROM_IDX_W  = 7;
	localparam int unsigned Q30_W      = 31;

	// Q30 rotation step of one degree
	localparam logic [63:0] Q30_ONE  = 64'd1073741824;
	localparam logic [63:0] Q30_COS1 = 64'd1073578288;
	localparam logic [63:0] Q30_SIN1 = 64'd18739379;

	// First-quadrant cosine table, one entry per degree 0..90
	typedef logic [ROM_DEPTH-1:0][Q30_W-1:0] cos_rom_t;

	// One accepted command as held in the input register
	typedef struct packed {
		logic                 action;
		logic [SPEED_W-1:0]   speed;
		logic [DEG_W-1:0]     heading_deg;
		logic [DEG_W-1:0]     attitude_deg;
		logic [ROT_W-1:0]     rotation;
	} cmd_t;

	// Builds the table at elaboration: Q30 unit vector rotated a degree at a time,
	// then rounded half up to the requested number of fraction bits.
	function automatic cos_rom_t cos_rom(input int unsigned frac);
		cos_rom_t    q;
		cos_rom_t    r;
		logic [63:0] c;
		logic [63:0] s;
		logic [63:0] nc;
		logic [63:0] ns;
		logic [63:0] v;
		int          sh;
		q = '0;
		r = '0;
		c = Q30_ONE;
		s = 64'd0;
		q[0]  = Q30_W'(Q30_ONE);
		q[90] = '0;
		for (int d = 1; d <= 45; d++) begin
			nc = (c * Q30_COS1 - s * Q30_SIN1 + (64'd1 << 29)) >> 30;
			ns = (s * Q30_COS1 + c * Q30_SIN1 + (64'd1 << 29)) >> 30;
			c = nc;
			s = ns;
			q[d]      = Q30_W'(c);
			q[90 - d] = Q30_W'(s);
		end
		sh = 30 - int'(frac);
		for (int i = 0; i < int'(ROM_DEPTH); i++) begin
			v = 64'(q[i]);
			r[i] = Q30_W'((v + (64'd1 << (sh - 1))) >> sh);
		end
		return r;
	endfunction

endpackage

>>> sv/owsm_wheel.sv
// One wheel lane: angle reduction, cosine lookup, scaling, rotation sum and saturation.
module owsm_wheel
	import owsm_pkg::*;
#(
	parameter int unsigned COS_FRACTION_BITS = 15,
	parameter int unsigned WHEEL             = 0
) (
	input  logic [SPEED_W-1:0] speed,
	input  logic [DEG_W-1:0]   heading_deg,
	input  logic [DEG_W-1:0]   attitude_deg,
	input  logic [ROT_W-1:0]   rotation,
	output dir_t               dir,
	output logic [SPEED_W-1:0] wheel_speed
);

	localparam int unsigned COS_W  = COS_FRACTION_BITS + 1;
	localparam int unsigned PROD_W = SPEED_W + COS_W;
	localparam cos_rom_t    COS_ROM = cos_rom(COS_FRACTION_BITS);
	// 1080 is a multiple of 360 that keeps the raw difference non-negative
	localparam logic [10:0] OFFSET = 11'(1080 - 45 - 90 * WHEEL);

	logic [10:0]           raw;
	logic [8:0]            deg;
	logic [ROM_IDX_W-1:0]  idx;
	logic                  neg;
	logic [COS_W-1:0]      mag;
	logic [PROD_W-1:0]     prod;
	logic [SPEED_W-1:0]    scaled;
	logic signed [17:0]    cos_term;
	logic signed [17:0]    sum;
	logic [16:0]           abs_sum;

	// Degree difference reduced mod 360
	always_comb begin
		raw = {2'b00, heading_deg} - {2'b00, attitude_deg} + OFFSET;
		if (raw >= 11'd1440)
			deg = 9'(raw - 11'd1440);
		else if (raw >= 11'd1080)
			deg = 9'(raw - 11'd1080);
		else if (raw >= 11'd720)
			deg = 9'(raw - 11'd720);
		else if (raw >= 11'd360)
			deg = 9'(raw - 11'd360);
		else
			deg = 9'(raw);
	end

	// Quadrant folding onto the 0..90 table
	always_comb begin
		if (deg <= 9'd90) begin
			idx = ROM_IDX_W'(deg);
			neg = 1'b0;
		end else if (deg <= 9'd180) begin
			idx = ROM_IDX_W'(9'd180 - deg);
			neg = 1'b1;
		end else if (deg <= 9'd270) begin
			idx = ROM_IDX_W'(deg - 9'd180);
			neg = 1'b1;
		end else begin
			idx = ROM_IDX_W'(9'd360 - deg);
			neg = 1'b0;
		end
		mag = COS_ROM[idx][COS_W-1:0];
	end

	// Scale, truncate toward zero, add rotation
	always_comb begin
		prod     = PROD_W'(speed) * PROD_W'(mag);
		scaled   = prod[COS_FRACTION_BITS +: SPEED_W];
		cos_term = neg ? 18'sd0 - $signed({2'b00, scaled}) : $signed({2'b00, scaled});
		sum      = cos_term + $signed({{2{rotation[ROT_W-1]}}, rotation});
	end

	// Direction by sign, magnitude saturated
	always_comb begin
		if (sum > 18'sd0)
			dir = DIR_FWD;
		else if (sum < 18'sd0)
			dir = DIR_REV;
		else
			dir = DIR_BRAKE;
		abs_sum     = sum[17] ? 17'(18'sd0 - sum) : sum[16:0];
		wheel_speed = abs_sum[16] ? {SPEED_W{1'b1}} : abs_sum[SPEED_W-1:0];
	end

endmodule

>>> sv/omni_wheel_speed_mixer_core.sv
// Top level of the four-wheel omni drive speed mixer.
//
//  channel   direction  tdata                                tuser
//  s_        in         speed, heading, attitude, rotation   action
//  m_        out        wheel1..4 dir, wheel1..4 speed       drive_enable
//
// Two register stages: command register, then result register. One transaction
// per cycle is sustained while m_tready is high; the four wheel lanes work in
// parallel between the two registers, each with one table lookup and one multiply.
// s_tready drops only when both registers are full and m_tready is low.
// arst_n clears both valid flags; payload registers are not reset.
module omni_wheel_speed_mixer_core
	import owsm_pkg::*;
#(
	parameter int unsigned COS_FRACTION_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// speed[15:0], heading_deg[24:16], attitude_deg[33:25], rotation[49:34], zero fill
	input  logic [55:0] s_tdata,
	// action
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// wheel1_dir[1:0] .. wheel4_dir[7:6], wheel1_speed[23:8] .. wheel4_speed[71:56]
	output logic [71:0] m_tdata,
	// drive_enable
	output logic        m_tuser
);

	cmd_t               cmd_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic [71:0]        data_s2;
	logic               enable_s2;
	logic               advance;
	dir_t               lane_dir   [NUM_WHEELS];
	logic [SPEED_W-1:0] lane_speed [NUM_WHEELS];
	logic [71:0]        result;

	// Handshake: the result register frees when taken or empty
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.action       <= s_tuser;
			cmd_s1.speed        <= s_tdata[15:0];
			cmd_s1.heading_deg  <= s_tdata[24:16];
			cmd_s1.attitude_deg <= s_tdata[33:25];
			cmd_s1.rotation     <= s_tdata[49:34];
		end
	end

	// Wheel lanes
	for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_wheel
		owsm_wheel #(
			.COS_FRACTION_BITS(COS_FRACTION_BITS),
			.WHEEL(k)
		) u_wheel (
			.speed(cmd_s1.speed),
			.heading_deg(cmd_s1.heading_deg),
			.attitude_deg(cmd_s1.attitude_deg),
			.rotation(cmd_s1.rotation),
			.dir(lane_dir[k]),
			.wheel_speed(lane_speed[k])
		);
	end

	// Result packing, stop forces brake at zero speed
	always_comb begin
		result = '0;
		for (int k = 0; k < NUM_WHEELS; k++) begin
			if (cmd_s1.action) begin
				result[2*k +: 2]       = DIR_BRAKE;
				result[8 + 16*k +: 16] = '0;
			end else begin
				result[2*k +: 2]       = lane_dir[k];
				result[8 + 16*k +: 16] = lane_speed[k];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_s2   <= result;
			enable_s2 <= !cmd_s1.action;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = enable_s2;

endmodule
